FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define QFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/qfa_pkg.sv
// Package: operation codes, widths and the side word of the Q24.8 ALU
`default_nettype none
package qfa_pkg;
    localparam int DATA_W = 32;
    localparam int OP_W   = 4;

    localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
    localparam logic [OP_W-1:0] OP_GT      = 4'd4;
    localparam logic [OP_W-1:0] OP_GE      = 4'd5;
    localparam logic [OP_W-1:0] OP_LT      = 4'd6;
    localparam logic [OP_W-1:0] OP_LE      = 4'd7;
    localparam logic [OP_W-1:0] OP_EQ      = 4'd8;
    localparam logic [OP_W-1:0] OP_NE      = 4'd9;
    localparam logic [OP_W-1:0] OP_MIN     = 4'd10;
    localparam logic [OP_W-1:0] OP_MAX     = 4'd11;
    localparam logic [OP_W-1:0] OP_INC     = 4'd12;
    localparam logic [OP_W-1:0] OP_DEC     = 4'd13;
    localparam logic [OP_W-1:0] OP_TO_INT  = 4'd14;
    localparam logic [OP_W-1:0] OP_FROM_INT = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        logic              cmp;
        logic              dz;
        logic              neg;
    } t_qfa_side;
endpackage
`default_nettype wire

FILE: hw/rtl/qfa_if.sv
// Word channels of the ALU: operand input and result output
`default_nettype none
interface qfa_in_if import qfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    modport source (output valid, output operation, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input operation, input operand_a, input operand_b,
                  output ready);
endinterface

interface qfa_out_if import qfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [DATA_W-1:0] result_value;
    logic              compare_true;
    logic              divide_by_zero;
    modport source (output valid, output result_value, output compare_true,
                    output divide_by_zero, input ready);
    modport sink (input valid, input result_value, input compare_true,
                  input divide_by_zero, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/qfa_front.sv
// Front stages: operand register, multiply, simple operations and divider setup
`default_nettype none
module qfa_front import qfa_pkg::*; #(
    parameter int FB = 8,
    parameter int DW = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [DATA_W-1:0] i_a,
    input  wire logic [DATA_W-1:0] i_b,
    output logic                   o_valid,
    output t_qfa_side              o_side,
    output logic [DW-1:0]          o_divd,
    output logic [DATA_W-1:0]      o_dvs
);
    logic                       r1_v;
    logic [OP_W-1:0]            r1_op;
    logic signed [DATA_W-1:0]   r1_a;
    logic signed [DATA_W-1:0]   r1_b;
    logic signed [2*DATA_W-1:0] r1_prod;
    t_qfa_side                  n_side;
    logic [DATA_W-1:0]          w_amag;
    logic [DATA_W-1:0]          w_bmag;
    logic signed [2*DATA_W-1:0] w_psh;
    logic signed [DATA_W-1:0]   w_tint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            o_valid <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op   <= i_op;
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_prod <= $signed(i_a) * $signed(i_b);
            o_side  <= n_side;
            o_divd  <= {w_amag, {FB{1'b0}}};
            o_dvs   <= w_bmag;
        end
    end

    assign w_amag = r1_a[DATA_W-1] ? (~r1_a + 1'b1) : r1_a;
    assign w_bmag = r1_b[DATA_W-1] ? (~r1_b + 1'b1) : r1_b;
    assign w_psh  = r1_prod >>> FB;
    assign w_tint = r1_a >>> FB;

    always_comb begin
        n_side     = '0;
        n_side.op  = r1_op;
        n_side.neg = r1_a[DATA_W-1] ^ r1_b[DATA_W-1];
        case (r1_op)
            OP_ADD:      n_side.val = r1_a + r1_b;
            OP_SUB:      n_side.val = r1_a - r1_b;
            OP_MUL:      n_side.val = w_psh[DATA_W-1:0];
            OP_DIV:      n_side.dz  = (r1_b == '0);
            OP_GT:       n_side.cmp = (r1_a > r1_b);
            OP_GE:       n_side.cmp = (r1_a >= r1_b);
            OP_LT:       n_side.cmp = (r1_a < r1_b);
            OP_LE:       n_side.cmp = (r1_a <= r1_b);
            OP_EQ:       n_side.cmp = (r1_a == r1_b);
            OP_NE:       n_side.cmp = (r1_a != r1_b);
            OP_MIN:      n_side.val = (r1_a <= r1_b) ? r1_a : r1_b;
            OP_MAX:      n_side.val = (r1_a > r1_b) ? r1_a : r1_b;
            OP_INC:      n_side.val = r1_a + 1'b1;
            OP_DEC:      n_side.val = r1_a - 1'b1;
            OP_TO_INT:   n_side.val = w_tint;
            OP_FROM_INT: n_side.val = r1_a << FB;
            default:     n_side.val = '0;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/qfa_div_cell.sv
// Divider cell: one restoring quotient bit, side word handed on
`default_nettype none
module qfa_div_cell import qfa_pkg::*; #(
    parameter int DW = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_qfa_side         i_side,
    input  wire logic [DATA_W-1:0] i_rem,
    input  wire logic [DW-1:0]     i_divd,
    input  wire logic [DATA_W-1:0] i_dvs,
    output logic                   o_valid,
    output t_qfa_side              o_side,
    output logic [DATA_W-1:0]      o_rem,
    output logic [DW-1:0]          o_divd,
    output logic [DATA_W-1:0]      o_dvs
);
    logic [DATA_W:0] w_trial;
    logic [DATA_W:0] w_diff;
    logic            w_ge;

    assign w_trial = {i_rem, i_divd[DW-1]};
    assign w_diff  = w_trial - {1'b0, i_dvs};
    assign w_ge    = !w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_rem  <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            o_divd <= {i_divd[DW-2:0], w_ge};
            o_dvs  <= i_dvs;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/fixed_point_q24_8_alu.sv
// Top level: signed Q24.8 fixed-point ALU with a pipelined divider chain
//
// Every operation passes the same pipeline, so results leave in input order and one
// word is accepted per cycle while the pipeline is not stalled. The pipeline has two front
// stages (operand register, multiply and simple operations), one divider
// cell per quotient bit (32 + FRACTION_BITS cells), and the output register.
// The whole pipeline stalls only while the output word is held by the sink.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_q24_8_alu import qfa_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qfa_in_if.sink     i_in,
    qfa_out_if.source  o_out
);
    localparam int DW = DATA_W + FRACTION_BITS;

    logic                  w_en;
    logic                  c_v    [DW+1];
    t_qfa_side             c_side [DW+1];
    logic [DATA_W-1:0]     c_rem  [DW+1];
    logic [DW-1:0]         c_divd [DW+1];
    logic [DATA_W-1:0]     c_dvs  [DW+1];
    logic [DW-1:0]         w_qs;
    logic [DATA_W-1:0]     n_val;
    logic                  r_ov;
    logic [DATA_W-1:0]     r_val;
    logic                  r_cmp;
    logic                  r_dz;

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    qfa_front #(.FB(FRACTION_BITS), .DW(DW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_op    (i_in.operation),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .o_valid (c_v[0]),
        .o_side  (c_side[0]),
        .o_divd  (c_divd[0]),
        .o_dvs   (c_dvs[0])
    );
    assign c_rem[0] = '0;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        qfa_div_cell #(.DW(DW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_v[g]),
            .i_side  (c_side[g]),
            .i_rem   (c_rem[g]),
            .i_divd  (c_divd[g]),
            .i_dvs   (c_dvs[g]),
            .o_valid (c_v[g+1]),
            .o_side  (c_side[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_divd  (c_divd[g+1]),
            .o_dvs   (c_dvs[g+1])
        );
    end

    assign w_qs = c_side[DW].neg ? (~c_divd[DW] + 1'b1) : c_divd[DW];

    always_comb begin
        n_val = c_side[DW].val;
        if (c_side[DW].op == OP_DIV) begin
            n_val = c_side[DW].dz ? '0 : w_qs[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= c_v[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_val <= n_val;
            r_cmp <= c_side[DW].cmp;
            r_dz  <= c_side[DW].dz;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.result_value   = r_val;
    assign o_out.compare_true   = r_cmp;
    assign o_out.divide_by_zero = r_dz;

    `QFA_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, r_ov && r_dz, r_val == '0)
    `QFA_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, r_ov, !(r_cmp && r_dz))
    `QFA_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_ov && !o_out.ready, r_ov && $stable(r_val))
endmodule
`default_nettype wire
